/* hdl/breakbeat_slice_chooser_defines.svh */
// ----------------------------------------------------------------------------
// Slice chooser assertion macros
// Shared property wrappers for the checker; clk and rst_n come from the user.
// ----------------------------------------------------------------------------
`ifndef BREAKBEAT_SLICE_CHOOSER_DEFINES_SVH
`define BREAKBEAT_SLICE_CHOOSER_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define BSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slice chooser check failed");

// Next-cycle implication, held off while in reset.
`define BSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slice chooser check failed");

`endif

/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// Slice chooser package
// Widths, Q1.16 constants, register codes, the locked-weight table and the
// pipeline record shared by the slice chooser modules.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int PHRASE_BITS = 6;
    localparam int BAR_W       = 6;
    localparam int NUM_STAGES  = 6;

    localparam logic [BAR_W-1:0] BAR_MASK =
        (PHRASE_BITS >= BAR_W) ? {BAR_W{1'b1}} : BAR_W'((1 << PHRASE_BITS) - 1);

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] ESC_RESET = 17'd6554;

    typedef enum logic [2:0] {
        REG_COMPLEXITY = 3'd0,
        REG_ANCHOR     = 3'd1,
        REG_ROLL       = 3'd2,
        REG_FILL       = 3'd3,
        REG_BARS       = 3'd4,
        REG_ESCAPE     = 3'd5
    } reg_index_t;

    // Per-slice beat-lock weight, Q1.16.
    function automatic logic [16:0] locked_weight(input logic [2:0] slice);
        logic [16:0] w;
        case (slice)
            3'd0:    w = 17'd0;
            3'd1:    w = 17'd32768;
            3'd2:    w = 17'd65536;
            3'd3:    w = 17'd45875;
            3'd4:    w = 17'd0;
            3'd5:    w = 17'd32768;
            3'd6:    w = 17'd65536;
            3'd7:    w = 17'd78643;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // Pipeline handshake state handed from the flow controller to the datapath.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } flow_t;

    // One record travels down the pipe; each stage fills in its own fields.
    typedef struct packed {
        logic [2:0]  cur;
        logic [2:0]  beat;
        logic [15:0] r1;
        logic [15:0] r2;
        logic [15:0] r3;
        logic [15:0] r4;
        logic        fill;
        logic        c_le;
        logic [33:0] prod_c;
        logic [33:0] prod_a;
        logic [33:0] prod_r;
        logic [17:0] c_adj;
        logic [16:0] a_adj;
        logic [16:0] ro_adj;
        logic        move;
        logic        snap;
        logic        escape;
        logic [16:0] a_clamp;
        logic [33:0] prod_wb;
        logic [33:0] prod_wc;
        logic [16:0] w_beat;
        logic [16:0] w_cur;
        logic [18:0] p_swap;
        logic        rep;
        logic [2:0]  next;
    } stage_t;

endpackage

/* hdl/bsc_flow.sv */
// ----------------------------------------------------------------------------
// Slice chooser flow control
// Per-stage valid bits and load enables; a stage loads when it is empty or
// the stage after it moves on, so bubbles close up under back-pressure.
// ----------------------------------------------------------------------------
module bsc_flow (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    output bsc_pkg::flow_t flow
);

    logic [bsc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [bsc_pkg::NUM_STAGES-1:0] valid_next;
    logic [bsc_pkg::NUM_STAGES-1:0] src_valid;
    logic [bsc_pkg::NUM_STAGES:0]   rdy;

    always_comb
    begin
        rdy[bsc_pkg::NUM_STAGES] = out_ready;
        for (int i = bsc_pkg::NUM_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        src_valid = {valid_reg[bsc_pkg::NUM_STAGES-2:0], in_valid};
        for (int i = 0; i < bsc_pkg::NUM_STAGES; i++)
        begin
            valid_next[i] = rdy[i] ? src_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = rdy[0];
    assign flow.load  = rdy[bsc_pkg::NUM_STAGES-1:0] & src_valid;
    assign flow.valid = valid_reg;

endmodule

/* hdl/breakbeat_slice_chooser.sv */
// ----------------------------------------------------------------------------
// Breakbeat slice chooser
// Takes one request per clock while the output is not stalled. A request
// accepted at a clock edge passes through each stage register to the
// output; one result per request, in order. The datapath has six register
// stages in three pairs: a multiply stage followed by the stage that uses
// its product, for the fill scaling, the anchor weighting and the swap
// chance. A stalled output holds its result and the pipe keeps accepting
// until every stage holds a request. The user must write the knobs through
// the cfg port only while no request is in flight; the block does not
// enforce it. The stages that need the knobs read them directly.
// ----------------------------------------------------------------------------
module breakbeat_slice_chooser (
    input  logic        clk,
    input  logic        rst_n,
    // request: [2:0] slice now playing, [5:3] eighth within the bar,
    // [11:6] bar_index, [27:12] rand_first, [43:28] rand_second,
    // [59:44] rand_third, [75:60] rand_fourth, [79:76] zero
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result: [2:0] next_slice, [7:3] zero
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // knob writes: index per bsc_pkg::reg_index_t
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int NS = bsc_pkg::NUM_STAGES;

    // ---------------------------------------------------------------- knobs
    logic [16:0] complexity_reg;
    logic [16:0] anchor_reg;
    logic [16:0] roll_reg;
    logic [16:0] fill_reg;
    logic [6:0]  bars_reg;
    logic [16:0] escape_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complexity_reg <= '0;
            anchor_reg     <= '0;
            roll_reg       <= '0;
            fill_reg       <= '0;
            bars_reg       <= '0;
            escape_reg     <= bsc_pkg::ESC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_COMPLEXITY: complexity_reg <= cfg_data;
                bsc_pkg::REG_ANCHOR:     anchor_reg     <= cfg_data;
                bsc_pkg::REG_ROLL:       roll_reg       <= cfg_data;
                bsc_pkg::REG_FILL:       fill_reg       <= cfg_data;
                bsc_pkg::REG_BARS:       bars_reg       <= cfg_data[6:0];
                bsc_pkg::REG_ESCAPE:     escape_reg     <= cfg_data;
                default:                 ;  // unused index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------- flow control
    bsc_pkg::flow_t flow;

    bsc_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .flow      (flow)
    );

    // -------------------------------------------------------------- datapath
    bsc_pkg::stage_t st_reg  [NS];
    bsc_pkg::stage_t st_next [NS];

    // Fill-bar detection and clamped fill amount.
    logic [bsc_pkg::BAR_W-1:0] bar_in;
    logic                      fill_hit;
    logic [16:0]               fill_clamp;
    logic [16:0]               fill_inv;
    logic [16:0]               c_dist;
    logic                      c_le;

    assign bar_in     = s_tdata[11:6] & bsc_pkg::BAR_MASK;
    assign fill_hit   = (bars_reg != 7'd0) && ({1'b0, bar_in} == bars_reg - 7'd1);
    assign fill_clamp = (fill_reg > bsc_pkg::ONE_Q16) ? bsc_pkg::ONE_Q16 : fill_reg;
    assign fill_inv   = bsc_pkg::ONE_Q16 - fill_clamp;
    assign c_le       = complexity_reg <= bsc_pkg::ONE_Q16;
    // Distance of complexity from one; the fill pulls it toward one.
    assign c_dist     = c_le ? (bsc_pkg::ONE_Q16 - complexity_reg)
                             : (complexity_reg - bsc_pkg::ONE_Q16);

    // Stage 0: unpack the request and form the three fill products.
    always_comb
    begin
        st_next[0]        = '0;
        st_next[0].cur    = s_tdata[2:0];
        st_next[0].beat   = s_tdata[5:3];
        st_next[0].r1     = s_tdata[27:12];
        st_next[0].r2     = s_tdata[43:28];
        st_next[0].r3     = s_tdata[59:44];
        st_next[0].r4     = s_tdata[75:60];
        st_next[0].fill   = fill_hit;
        st_next[0].c_le   = c_le;
        st_next[0].prod_c = c_dist * fill_clamp;
        st_next[0].prod_a = anchor_reg * fill_inv;
        st_next[0].prod_r = roll_reg * fill_inv;
    end

    // Stage 1: apply the fill, or pass the knobs through outside the fill bar.
    always_comb
    begin
        st_next[1] = st_reg[0];
        if (st_reg[0].fill)
        begin
            st_next[1].c_adj  = st_reg[0].c_le
                ? ({1'b0, complexity_reg} + st_reg[0].prod_c[33:16])
                : ({1'b0, complexity_reg} - st_reg[0].prod_c[33:16]);
            st_next[1].a_adj  = st_reg[0].prod_a[32:16];
            st_next[1].ro_adj = st_reg[0].prod_r[32:16];
        end
        else
        begin
            st_next[1].c_adj  = {1'b0, complexity_reg};
            st_next[1].a_adj  = anchor_reg;
            st_next[1].ro_adj = roll_reg;
        end
    end

    // Stage 2: branch tests on the first draws, clamp anchor, weight products.
    always_comb
    begin
        st_next[2]         = st_reg[1];
        // A roll above one always stays.
        st_next[2].move    = (st_reg[1].ro_adj <= bsc_pkg::ONE_Q16) &&
                             ({1'b0, st_reg[1].r1} < bsc_pkg::ONE_Q16 - st_reg[1].ro_adj);
        // Snap compares against the unclamped anchor.
        st_next[2].snap    = {1'b0, st_reg[1].r3} < st_reg[1].a_adj;
        st_next[2].escape  = {1'b0, st_reg[1].r2} < escape_reg;
        st_next[2].a_clamp = (st_reg[1].a_adj > bsc_pkg::ONE_Q16) ? bsc_pkg::ONE_Q16
                                                                   : st_reg[1].a_adj;
        st_next[2].prod_wb = bsc_pkg::locked_weight(st_reg[1].beat) * st_next[2].a_clamp;
        st_next[2].prod_wc = bsc_pkg::locked_weight(st_reg[1].cur) * st_next[2].a_clamp;
    end

    // Stage 3: blend free weight (one) and locked weight by the anchor.
    logic [16:0] a_inv;
    logic [33:0] sum_wb;
    logic [33:0] sum_wc;

    always_comb
    begin
        a_inv             = bsc_pkg::ONE_Q16 - st_reg[2].a_clamp;
        sum_wb            = {1'b0, a_inv, 16'd0} + st_reg[2].prod_wb;
        sum_wc            = {1'b0, a_inv, 16'd0} + st_reg[2].prod_wc;
        st_next[3]        = st_reg[2];
        st_next[3].w_beat = sum_wb[32:16];
        st_next[3].w_cur  = sum_wc[32:16];
    end

    // Stage 4: swap chance and the repeat test.
    logic [34:0] prod_swap;

    always_comb
    begin
        prod_swap         = st_reg[3].c_adj * st_reg[3].w_beat;
        st_next[4]        = st_reg[3];
        st_next[4].p_swap = prod_swap[34:16];
        // A weight of one or more never repeats.
        st_next[4].rep    = (st_reg[3].w_cur < bsc_pkg::ONE_Q16) &&
                            ({1'b0, st_reg[3].r3} < bsc_pkg::ONE_Q16 - st_reg[3].w_cur);
    end

    // Stage 5: pick the slice.
    logic        swap;
    logic [17:0] esc_prod;
    logic [2:0]  esc_step;

    always_comb
    begin
        swap       = {3'd0, st_reg[4].r2} < st_reg[4].p_swap;
        esc_prod   = {2'd0, st_reg[4].r3} * 18'd3;
        // Escape jumps two to four slices ahead.
        esc_step   = 3'd2 + {1'b0, esc_prod[17:16]};
        st_next[5] = st_reg[4];
        if (st_reg[4].move)
        begin
            if (swap)
                st_next[5].next = st_reg[4].r3[15:13];
            else if (st_reg[4].snap)
                st_next[5].next = st_reg[4].beat;
            else
                st_next[5].next = st_reg[4].cur + 3'd1;
        end
        else
        begin
            if (st_reg[4].escape)
                st_next[5].next = st_reg[4].cur + esc_step;
            else if (st_reg[4].rep)
                st_next[5].next = st_reg[4].cur;
            else if (!st_reg[4].r4[15])
                st_next[5].next = st_reg[4].cur + 3'd1;
            else
                st_next[5].next = st_reg[4].cur - 3'd1;
        end
    end

    // Advance each stage only on its load enable; payload needs no reset.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (flow.load[k])
                st_reg[k] <= st_next[k];
        end
    end

    // -------------------------------------------------------------- result
    assign m_tvalid = flow.valid[NS-1];
    assign m_tdata  = {5'd0, st_reg[NS-1].next};

endmodule

/* hdl/bsc_checker.sv */
// ----------------------------------------------------------------------------
// Slice chooser port checker
// Watches the top-level ports for handshake and pipeline behavior.
// ----------------------------------------------------------------------------
`include "breakbeat_slice_chooser_defines.svh"

module bsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // A stalled result holds.
    `BSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Padding above the slice stays zero.
    `BSC_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[7:3] == 5'd0)
    // An empty output stage means the pipe can always take a request.
    `BSC_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready)
    // A draining output frees every stage.
    `BSC_ASSERT_NOW(a_drain_ready, m_tready, s_tready)

endmodule

bind breakbeat_slice_chooser bsc_checker u_bsc_checker (.*);

/* dv/slice_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slice chooser checker
// Mirrors the knob writes, predicts the next slice for every accepted
// request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module slice_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [79:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output int          mismatches,
    output int          checked,
    output int          outstanding
);

    localparam logic [63:0] UNITY = 64'd65536;

    logic [16:0] complexity;
    logic [16:0] anchor;
    logic [16:0] roll;
    logic [16:0] fill;
    logic [6:0]  bars;
    logic [16:0] escape;

    logic [2:0]  expected_slices [$];
    logic [2:0]  want;

    // Beat-lock weight blended by the clamped anchor amount.
    function automatic logic [63:0] lock_weight(input logic [2:0] s, input logic [63:0] anch);
        logic [63:0] a;
        logic [63:0] level;
        a = (anch > UNITY) ? UNITY : anch;
        case (s)
            3'd1, 3'd5: level = 64'd32768;
            3'd2, 3'd6: level = 64'd65536;
            3'd3:       level = 64'd45875;
            3'd7:       level = 64'd78643;
            default:    level = 64'd0;
        endcase
        return (UNITY * (UNITY - a) + level * a) >> 16;
    endfunction

    function automatic logic [2:0] choose_slice(input logic [79:0] req);
        logic [2:0]  cur;
        logic [2:0]  beat;
        logic [5:0]  bar;
        logic [63:0] d1, d2, d3, d4;
        logic [63:0] cx, an, rl, fl, w, p_swap;
        logic [2:0]  pick;
        cur  = req[2:0];
        beat = req[5:3];
        bar  = req[11:6] & bsc_pkg::BAR_MASK;
        d1   = 64'(req[27:12]);
        d2   = 64'(req[43:28]);
        d3   = 64'(req[59:44]);
        d4   = 64'(req[75:60]);
        cx   = 64'(complexity);
        an   = 64'(anchor);
        rl   = 64'(roll);
        // Last bar of the phrase: push complexity toward one, pull anchor and roll down.
        if (bars != 7'd0 && 64'(bar) == 64'(bars) - 64'd1) begin
            fl = (64'(fill) > UNITY) ? UNITY : 64'(fill);
            if (cx <= UNITY)
                cx = cx + (((UNITY - cx) * fl) >> 16);
            else
                cx = cx - (((cx - UNITY) * fl) >> 16);
            an = (an * (UNITY - fl)) >> 16;
            rl = (rl * (UNITY - fl)) >> 16;
        end
        if (rl <= UNITY && d1 < UNITY - rl) begin
            p_swap = (cx * lock_weight(beat, an)) >> 16;
            if (d2 < p_swap)
                pick = d3[15:13];
            else if (d3 < an)
                pick = beat;
            else
                pick = cur + 3'd1;
        end else if (d2 < 64'(escape)) begin
            pick = cur + 3'd2 + 3'((d3 * 64'd3) >> 16);
        end else begin
            w = lock_weight(cur, an);
            if (w < UNITY && d3 < UNITY - w)
                pick = cur;
            else
                pick = (d4 < 64'd32768) ? cur + 3'd1 : cur - 3'd1;
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            complexity  = 17'd0;
            anchor      = 17'd0;
            roll        = 17'd0;
            fill        = 17'd0;
            bars        = 7'd0;
            escape      = bsc_pkg::ESC_RESET;
            expected_slices.delete();
            mismatches  = 0;
            checked     = 0;
            outstanding = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_slices.push_back(choose_slice(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_slices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: next_slice %0d with nothing pending",
                                 m_tdata[2:0]);
                end else begin
                    want = expected_slices.pop_front();
                    checked++;
                    if (m_tdata[2:0] !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: next_slice expected %0d, got %0d",
                                     want, m_tdata[2:0]);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    bsc_pkg::REG_COMPLEXITY: complexity = cfg_data;
                    bsc_pkg::REG_ANCHOR:     anchor     = cfg_data;
                    bsc_pkg::REG_ROLL:       roll       = cfg_data;
                    bsc_pkg::REG_FILL:       fill       = cfg_data;
                    bsc_pkg::REG_BARS:       bars       = cfg_data[6:0];
                    bsc_pkg::REG_ESCAPE:     escape     = cfg_data;
                    default:                 ;
                endcase
            end
            outstanding = expected_slices.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slice chooser testbench
// Drives directed and random slice requests through the chooser under a
// series of knob settings, with random gaps and output stalls plus one long
// output hold-off; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 10;
    localparam int PER_PHASE    = 103;
    localparam int HOLD_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    logic [79:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    int mismatches;
    int checked;
    int outstanding;
    int sent;
    int settings;
    int cycles;
    int stall_left;
    int held;
    bit idle_on;
    bit hold_request;

    breakbeat_slice_chooser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    slice_check slice_check_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .checked    (checked),
        .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Give up on a hung run: count cycles and bail out at the limit.
    initial begin
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Output side: random stall bursts while idling is on, and one long
    // hold-off when the stimulus asks for it, so the pipe fills and backs up.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                m_tready <= 1'b1;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // Offer one request, with an optional gap in front, and hold it until taken.
    // Valid stays high from one request to the next when there is no gap.
    task automatic send_request(input logic [2:0] cur, input logic [2:0] beat,
                                input logic [5:0] bar, input logic [15:0] d1,
                                input logic [15:0] d2, input logic [15:0] d3,
                                input logic [15:0] d4);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap != 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tdata  <= {4'd0, d4, d3, d2, d1, bar, beat, cur};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // Drop valid and wait until every pending result has come back.
    task automatic finish_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
    endtask

    // Write all six knobs back to back; only called with the block drained.
    task automatic program_knobs(input logic [16:0] c, input logic [16:0] a,
                                 input logic [16:0] r, input logic [16:0] f,
                                 input logic [16:0] b, input logic [16:0] e);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bsc_pkg::REG_COMPLEXITY;
        cfg_data  <= c;
        @(negedge clk);
        cfg_index <= bsc_pkg::REG_ANCHOR;
        cfg_data  <= a;
        @(negedge clk);
        cfg_index <= bsc_pkg::REG_ROLL;
        cfg_data  <= r;
        @(negedge clk);
        cfg_index <= bsc_pkg::REG_FILL;
        cfg_data  <= f;
        @(negedge clk);
        cfg_index <= bsc_pkg::REG_BARS;
        cfg_data  <= b;
        @(negedge clk);
        cfg_index <= bsc_pkg::REG_ESCAPE;
        cfg_data  <= e;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // Knob value biased toward zero, one and the top of the 17-bit range.
    function automatic logic [16:0] pick_knob();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return bsc_pkg::ONE_Q16;
            2:       return 17'h1FFFF;
            3, 4:    return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    // Random draw with extra weight on the ends of the range.
    function automatic logic [15:0] pick_draw();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [16:0] bars_now;
        logic [5:0]  bar;
        int          ph;
        int          n;

        rst_n        = 1'b0;
        s_tdata      = '0;
        s_tvalid     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = bsc_pkg::REG_COMPLEXITY;
        cfg_data     = '0;
        sent         = 0;
        settings     = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Reset knobs: no swap, no snap, no roll, so every request advances.
        send_request(3'd0, 3'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(3'd7, 3'd7, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        finish_burst();

        // Full complexity and anchor: swap chance follows the beat table.
        program_knobs(bsc_pkg::ONE_Q16, bsc_pkg::ONE_Q16, 17'd0, 17'd0, 17'd0,
                      bsc_pkg::ESC_RESET);
        send_request(3'd3, 3'd0, 6'd5, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_request(3'd3, 3'd2, 6'd5, 16'h0000, 16'h0000, 16'hE000, 16'h0000);
        send_request(3'd1, 3'd7, 6'd0, 16'h0000, 16'hFFFF, 16'h2000, 16'h0000);
        send_request(3'd5, 3'd3, 6'd9, 16'h0000, 16'd45874, 16'h0000, 16'h0000);
        send_request(3'd5, 3'd3, 6'd9, 16'h0000, 16'd45875, 16'h0000, 16'h0000);
        finish_burst();

        // Roll of one: always stay; escape steps, repeats and plus/minus one.
        program_knobs(17'd0, bsc_pkg::ONE_Q16, bsc_pkg::ONE_Q16, 17'd0, 17'd0,
                      17'd32768);
        send_request(3'd6, 3'd1, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(3'd6, 3'd1, 6'd0, 16'h0000, 16'd32767, 16'hFFFF, 16'h0000);
        send_request(3'd0, 3'd0, 6'd0, 16'h0000, 16'd32768, 16'h0000, 16'h0000);
        send_request(3'd7, 3'd0, 6'd0, 16'h0000, 16'd32768, 16'h0000, 16'h0000);
        send_request(3'd7, 3'd0, 6'd0, 16'h0000, 16'd32768, 16'h0000, 16'h8000);
        send_request(3'd2, 3'd0, 6'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF);
        finish_burst();

        // Complexity, anchor, roll and fill at their top: clamped fill on bar 63, roll above one elsewhere.
        program_knobs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd64, 17'd0);
        send_request(3'd4, 3'd6, 6'd63, 16'd100, 16'h0000, 16'hC000, 16'h0000);
        send_request(3'd4, 3'd6, 6'd62, 16'd100, 16'h0000, 16'hC000, 16'h0000);
        finish_burst();

        // One-bar phrase: every bar 0 is a partial fill.
        program_knobs(17'd40000, 17'd30000, 17'd20000, 17'd32768, 17'd1, 17'd65535);
        send_request(3'd1, 3'd5, 6'd0, 16'd30000, 16'd50000, 16'd20000, 16'd40000);
        send_request(3'd1, 3'd5, 6'd1, 16'd30000, 16'd50000, 16'd20000, 16'd40000);
        send_request(3'd6, 3'd4, 6'd0, 16'd10000, 16'd2000, 16'd60000, 16'd100);
        send_request(3'd6, 3'd4, 6'd0, 16'd60000, 16'd65535, 16'd5000, 16'd50000);
        finish_burst();

        // Phrase lengths out of reach of the bar field: no fill at all.
        program_knobs(bsc_pkg::ONE_Q16, 17'd0, 17'd0, bsc_pkg::ONE_Q16, 17'd127,
                      bsc_pkg::ONE_Q16);
        send_request(3'd3, 3'd7, 6'd63, 16'h1234, 16'h0100, 16'hA000, 16'h0000);
        finish_burst();
        program_knobs(17'd0, 17'd0, 17'd0, 17'd0, 17'd65, bsc_pkg::ESC_RESET);
        send_request(3'd2, 3'd2, 6'd63, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        finish_burst();

        // Random phases, each under fresh knobs. Phase 2 carries the long
        // output hold-off; the last phase runs with no idling on either side.
        for (ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 6))
                0:       bars_now = 17'd0;
                1:       bars_now = 17'd1;
                2:       bars_now = 17'd64;
                3:       bars_now = 17'($urandom_range(65, 127));
                default: bars_now = 17'($urandom_range(2, 16));
            endcase
            program_knobs(pick_knob(), pick_knob(), pick_knob(), pick_knob(),
                          bars_now, pick_knob());
            idle_on = (ph != PHASES - 1);
            if (ph == 2)
                hold_request = 1'b1;
            for (n = 0; n < PER_PHASE; n++) begin
                // Aim half the requests at the fill bar when one exists.
                if (bars_now != 17'd0 && bars_now <= 17'd64 && $urandom_range(0, 1) == 1)
                    bar = 6'(bars_now - 17'd1);
                else
                    bar = 6'($urandom_range(0, 63));
                send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), bar,
                             pick_draw(), pick_draw(), pick_draw(), pick_draw());
            end
            finish_burst();
        end

        // Let the pipe settle past its latency before the verdict.
        repeat (12) @(posedge clk);
        $display("Covered %0d requests under %0d knob settings, %0d results checked,",
                 sent, settings, checked);
        $display("including fill bars, clamped knobs, long output hold-off and idle-free run.");
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
